### hw/rtl/tqv_pkg.sv
// Torus quad vertex generator: shared types, constants and arithmetic helpers.
// No dependencies; imported by every module of the block.
package tqv_pkg;

    localparam int IDX_W     = 10;
    localparam int SEG_W     = 11;
    localparam int VIDX_W    = 11;
    localparam int RAD_W     = 16;
    localparam int POS_W     = 20;
    localparam int TEX_W     = 17;
    localparam int CORNER_W  = 3;
    localparam int PHASE_W   = 32;
    localparam int CW        = 35;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam int CORDIC_STEPS  = 24;
    localparam int CORDIC_STAGES = CORDIC_STEPS / 2;
    localparam int PH_DVD_W      = 44;
    localparam int PH_STAGES     = PH_DVD_W / 2;
    localparam int TX_DVD_W      = 28;
    localparam int TX_STAGES     = TX_DVD_W / 2;
    localparam int ANGLE_LAT     = PH_STAGES + CORDIC_STAGES + 2;
    localparam int TEX_PAD       = ANGLE_LAT - TX_STAGES;
    localparam int POS_LAT       = 4;
    localparam int PIPE_LAT      = ANGLE_LAT + POS_LAT;

    localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd5;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 35'sh026DD3B6A;
    localparam logic signed [CW-1:0] QUARTER_TURN = 35'sh040000000;
    localparam logic signed [CW-1:0] HALF_TURN = 35'sh080000000;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MINOR_RADIUS    = 3'd0,
        CFG_MAJOR_RADIUS    = 3'd1,
        CFG_RING_SEGMENTS   = 3'd2,
        CFG_COLUMN_SEGMENTS = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic [IDX_W-1:0] ring_index;
        logic [IDX_W-1:0] column_index;
    } quad_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [TEX_W-1:0]        tex_u;
        logic [TEX_W-1:0]        tex_v;
        logic [CORNER_W-1:0]     corner_number;
        logic                    last_corner;
    } vertex_t;

    typedef struct packed {
        logic                valid;
        logic [VIDX_W-1:0]   ri;
        logic [VIDX_W-1:0]   cj;
        logic [CORNER_W-1:0] corner;
    } issue_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

    function automatic logic ring_step(input logic [CORNER_W-1:0] n);
        logic r;
        case (n)
            3'd1, 3'd4, 3'd5: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic col_step(input logic [CORNER_W-1:0] n);
        logic r;
        case (n)
            3'd2, 3'd3, 3'd5: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    // One restoring division step: {quotient bit, new remainder}.
    function automatic logic [SEG_W:0] div_step(input logic [SEG_W-1:0] rem, input logic b,
                                                input logic [SEG_W-1:0] seg);
        logic [SEG_W:0] part;
        logic [SEG_W:0] diff;
        part = {rem, b};
        diff = part - {1'b0, seg};
        if (part >= {1'b0, seg}) begin
            return {1'b1, diff[SEG_W-1:0]};
        end
        return {1'b0, part[SEG_W-1:0]};
    endfunction

    function automatic cordic_t cordic_step(input cordic_t v, input logic [4:0] k);
        cordic_t r;
        logic signed [CW-1:0] a;
        a = $signed({{(CW-32){1'b0}}, ATAN_TURNS[k]});
        if (!v.z[CW-1]) begin
            r.x = v.x - (v.y >>> k);
            r.y = v.y + (v.x >>> k);
            r.z = v.z - a;
        end else begin
            r.x = v.x + (v.y >>> k);
            r.y = v.y - (v.x >>> k);
            r.z = v.z + a;
        end
        return r;
    endfunction

endpackage

### hw/rtl/tqv_seq.sv
// Quad sequencer: takes one quad request and issues its six corners, one a cycle while en is high.
// Depends on tqv_pkg.
module tqv_seq import tqv_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   s_valid,
    output logic   s_ready,
    input  quad_t  s_data,
    output issue_t iss
);

    logic                busy_reg, busy_next;
    logic [CORNER_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]    ri_reg, ri_next;
    logic [IDX_W-1:0]    cj_reg, cj_next;
    logic                take;

    assign s_ready = !busy_reg || (cnt_reg == LAST_CORNER && en);
    assign take    = s_valid && s_ready;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        ri_next   = ri_reg;
        cj_next   = cj_reg;
        if (busy_reg && en) begin
            if (cnt_reg == LAST_CORNER) begin
                busy_next = 1'b0;
                cnt_next  = '0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (take) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            ri_next   = s_data.ring_index;
            cj_next   = s_data.column_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        ri_reg <= ri_next;
        cj_reg <= cj_next;
    end

    always_comb begin
        iss.valid  = busy_reg;
        iss.ri     = {1'b0, ri_reg} + {{(VIDX_W-1){1'b0}}, ring_step(cnt_reg)};
        iss.cj     = {1'b0, cj_reg} + {{(VIDX_W-1){1'b0}}, col_step(cnt_reg)};
        iss.corner = cnt_reg;
    end

endmodule

### hw/rtl/tqv_angle.sv
// Angle unit: pipelined phase and texture dividers feeding a pipelined CORDIC.
// Depends on tqv_pkg; the pipeline advances only while en is high.
module tqv_angle import tqv_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [VIDX_W-1:0]    idx,
    input  logic [SEG_W-1:0]     seg,
    output logic signed [CW-1:0] cos_o,
    output logic signed [CW-1:0] sin_o,
    output logic [TEX_W-1:0]     tex_o
);

    // phase = round(idx * 2^32 / seg) mod 2^32, two quotient bits per stage
    logic [PH_DVD_W-1:0] ph_dvd_reg [PH_STAGES];
    logic [SEG_W-1:0]    ph_rem_reg [PH_STAGES];
    logic [SEG_W-1:0]    ph_seg_reg [PH_STAGES];
    logic [PHASE_W-1:0]  ph_quo_reg [PH_STAGES];

    for (genvar s = 0; s < PH_STAGES; s++) begin : g_ph
        logic [PH_DVD_W-1:0] dvd_in;
        logic [SEG_W-1:0]    rem_in, seg_in;
        logic [PHASE_W-1:0]  quo_in;
        logic [SEG_W:0]      st1_next, st2_next;
        if (s == 0) begin : g_first
            assign dvd_in = {1'b0, idx, 22'd0, seg[SEG_W-1:1]};
            assign rem_in = '0;
            assign seg_in = seg;
            assign quo_in = '0;
        end else begin : g_rest
            assign dvd_in = ph_dvd_reg[s-1];
            assign rem_in = ph_rem_reg[s-1];
            assign seg_in = ph_seg_reg[s-1];
            assign quo_in = ph_quo_reg[s-1];
        end
        assign st1_next = div_step(rem_in, dvd_in[PH_DVD_W-1], seg_in);
        assign st2_next = div_step(st1_next[SEG_W-1:0], dvd_in[PH_DVD_W-2], seg_in);
        always_ff @(posedge aclk) begin
            if (en) begin
                ph_dvd_reg[s] <= {dvd_in[PH_DVD_W-3:0], 2'b00};
                ph_rem_reg[s] <= st2_next[SEG_W-1:0];
                ph_seg_reg[s] <= seg_in;
                ph_quo_reg[s] <= {quo_in[PHASE_W-3:0], st1_next[SEG_W], st2_next[SEG_W]};
            end
        end
    end

    // quarter-turn reduction
    logic signed [CW-1:0] z0_next, z0_reg;
    logic                 flip0_next, flip0_reg;
    logic [PHASE_W-1:0]   phase;

    assign phase = ph_quo_reg[PH_STAGES-1];

    always_comb begin
        z0_next    = $signed({{(CW-PHASE_W){phase[PHASE_W-1]}}, phase});
        flip0_next = 1'b0;
        if (z0_next > QUARTER_TURN) begin
            z0_next    = z0_next - HALF_TURN;
            flip0_next = 1'b1;
        end else if (z0_next < -QUARTER_TURN) begin
            z0_next    = z0_next + HALF_TURN;
            flip0_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z0_reg    <= z0_next;
            flip0_reg <= flip0_next;
        end
    end

    // CORDIC, two micro-rotations per stage
    cordic_t cd_reg   [CORDIC_STAGES];
    logic    flip_reg [CORDIC_STAGES];

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cd
        cordic_t v_in, mid_next, v_next;
        logic    f_in;
        if (s == 0) begin : g_first
            assign v_in = '{x: CORDIC_GAIN, y: '0, z: z0_reg};
            assign f_in = flip0_reg;
        end else begin : g_rest
            assign v_in = cd_reg[s-1];
            assign f_in = flip_reg[s-1];
        end
        assign mid_next = cordic_step(v_in, 5'(2 * s));
        assign v_next   = cordic_step(mid_next, 5'(2 * s + 1));
        always_ff @(posedge aclk) begin
            if (en) begin
                cd_reg[s]   <= v_next;
                flip_reg[s] <= f_in;
            end
        end
    end

    logic signed [CW-1:0] cos_reg, sin_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= flip_reg[CORDIC_STAGES-1] ? -cd_reg[CORDIC_STAGES-1].x
                                                 : cd_reg[CORDIC_STAGES-1].x;
            sin_reg <= flip_reg[CORDIC_STAGES-1] ? -cd_reg[CORDIC_STAGES-1].y
                                                 : cd_reg[CORDIC_STAGES-1].y;
        end
    end

    assign cos_o = cos_reg;
    assign sin_o = sin_reg;

    // texture = floor((idx * 65536 + seg/2) / seg), saturated
    logic [TX_DVD_W-1:0] tx_dvd_reg [TX_STAGES];
    logic [SEG_W-1:0]    tx_rem_reg [TX_STAGES];
    logic [SEG_W-1:0]    tx_seg_reg [TX_STAGES];
    logic [TEX_W-1:0]    tx_quo_reg [TX_STAGES];
    logic                tx_ovf_reg [TX_STAGES];

    for (genvar s = 0; s < TX_STAGES; s++) begin : g_tx
        logic [TX_DVD_W-1:0] dvd_in;
        logic [SEG_W-1:0]    rem_in, seg_in;
        logic [TEX_W-1:0]    quo_in;
        logic                ovf_in;
        logic [SEG_W:0]      st1_next, st2_next;
        if (s == 0) begin : g_first
            assign dvd_in = {1'b0, idx, 6'd0, seg[SEG_W-1:1]};
            assign rem_in = '0;
            assign seg_in = seg;
            assign quo_in = '0;
            assign ovf_in = 1'b0;
        end else begin : g_rest
            assign dvd_in = tx_dvd_reg[s-1];
            assign rem_in = tx_rem_reg[s-1];
            assign seg_in = tx_seg_reg[s-1];
            assign quo_in = tx_quo_reg[s-1];
            assign ovf_in = tx_ovf_reg[s-1];
        end
        assign st1_next = div_step(rem_in, dvd_in[TX_DVD_W-1], seg_in);
        assign st2_next = div_step(st1_next[SEG_W-1:0], dvd_in[TX_DVD_W-2], seg_in);
        always_ff @(posedge aclk) begin
            if (en) begin
                tx_dvd_reg[s] <= {dvd_in[TX_DVD_W-3:0], 2'b00};
                tx_rem_reg[s] <= st2_next[SEG_W-1:0];
                tx_seg_reg[s] <= seg_in;
                tx_quo_reg[s] <= {quo_in[TEX_W-3:0], st1_next[SEG_W], st2_next[SEG_W]};
                tx_ovf_reg[s] <= ovf_in | quo_in[TEX_W-1] | quo_in[TEX_W-2];
            end
        end
    end

    logic [TEX_W-1:0] tex_dly_reg [TEX_PAD];

    always_ff @(posedge aclk) begin
        if (en) begin
            tex_dly_reg[0] <= tx_ovf_reg[TX_STAGES-1] ? {TEX_W{1'b1}} : tx_quo_reg[TX_STAGES-1];
            for (int k = 1; k < TEX_PAD; k++) begin
                tex_dly_reg[k] <= tex_dly_reg[k-1];
            end
        end
    end

    assign tex_o = tex_dly_reg[TEX_PAD-1];

endmodule

### hw/rtl/tqv_pos.sv
// Position unit: tube radius, ring projection and rounding to signed Q10.9, four stages.
// Depends on tqv_pkg; takes sine and cosine from the angle units.
module tqv_pos import tqv_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [RAD_W-1:0]        minor_radius,
    input  logic [RAD_W-1:0]        major_radius,
    input  logic signed [CW-1:0]    cos_a,
    input  logic signed [CW-1:0]    sin_a,
    input  logic signed [CW-1:0]    cos_b,
    input  logic signed [CW-1:0]    sin_b,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic signed [POS_W-1:0] pos_z
);

    localparam int PW  = RAD_W + 1 + CW;
    localparam int SW  = PW + 1;
    localparam int RW  = 28;
    localparam int MW  = 64;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [MW-1:0] v);
        if (v > 64'sd262144) begin
            return 20'sd262144;
        end
        if (v < -64'sd262144) begin
            return -20'sd262144;
        end
        return v[POS_W-1:0];
    endfunction

    logic signed [PW-1:0]    ra_reg, rs_reg;
    logic signed [CW-1:0]    cb1_reg, sb1_reg, cb2_reg, sb2_reg;
    logic signed [RW-1:0]    rho_reg;
    logic signed [POS_W-1:0] pz2_reg, pz3_reg, pz_reg;
    logic signed [RW+CW-1:0] mx_reg, my_reg;
    logic signed [POS_W-1:0] px_reg, py_reg;
    logic signed [SW-1:0]    rho_sum;
    logic signed [MW-1:0]    pz_sum, mx_sum, my_sum;
    logic signed [PW-1:0]    r_s;

    assign r_s = $signed({{(PW-RAD_W){1'b0}}, minor_radius});

    assign rho_sum = $signed({{(SW-RAD_W-30){1'b0}}, major_radius, 30'd0})
                   + SW'(ra_reg) + (SW'(1) <<< 21);
    assign pz_sum  = (MW'(rs_reg) + (MW'(1) <<< 28)) >>> 29;
    assign mx_sum  = (MW'(mx_reg) + (MW'(1) <<< 36)) >>> 37;
    assign my_sum  = (MW'(my_reg) + (MW'(1) <<< 36)) >>> 37;

    always_ff @(posedge aclk) begin
        if (en) begin
            ra_reg  <= PW'(r_s * PW'(cos_a));
            rs_reg  <= PW'(r_s * PW'(sin_a));
            cb1_reg <= cos_b;
            sb1_reg <= sin_b;

            rho_reg <= rho_sum[RW+21:22];
            pz2_reg <= sat_pos(pz_sum);
            cb2_reg <= cb1_reg;
            sb2_reg <= sb1_reg;

            mx_reg  <= (RW+CW)'(rho_reg) * (RW+CW)'(cb2_reg);
            my_reg  <= (RW+CW)'(rho_reg) * (RW+CW)'(sb2_reg);
            pz3_reg <= pz2_reg;

            px_reg  <= sat_pos(mx_sum);
            py_reg  <= sat_pos(my_sum);
            pz_reg  <= pz3_reg;
        end
    end

    assign pos_x = px_reg;
    assign pos_y = py_reg;
    assign pos_z = pz_reg;

endmodule

### hw/rtl/torus_quad_vertex_generator.sv
// Torus quad vertex generator, top level: registers, sequencer, angle and position units.
// Depends on tqv_pkg, tqv_seq, tqv_angle and tqv_pos.
//
// Usage:
//   s_* channel takes one quad request (ring_index, column_index) with valid/ready.
//   m_* channel returns six vertices per quad, corners 0..5, last_corner on corner 5.
//   cfg_we/cfg_index/cfg_wdata write radii and segment counts; write only when idle.
// Throughput: the next quad is taken as the current one issues its last corner; the six
//   corners share one vertex pipeline and result port, one per cycle unless stalled.
// Pipeline: after the request is accepted, the first vertex of a quad passes
//   22 phase divider stages, reduction, 12 CORDIC stages, the output
//   register and 4 position stages (the sequencer loads on the accepting edge);
//   the rest follow one per cycle while m_ready does not stall the pipeline.
// Stall: when a result waits and m_ready is low, the pipeline and the busy sequencer
//   freeze, though an idle sequencer still takes a request; nothing is lost or repeated.
// Reset: synchronous, active low; empties the pipeline, drops any quad in
//   progress and restores radii 1.0/2.0 and 360 segments each way.
module torus_quad_vertex_generator import tqv_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  quad_t                s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output vertex_t              m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [RAD_W-1:0] minor_reg, major_reg;
    logic [SEG_W-1:0] rseg_reg, cseg_reg;
    logic [SEG_W-1:0] rseg_eff, cseg_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minor_reg <= 16'd256;
            major_reg <= 16'd512;
            rseg_reg  <= 11'd360;
            cseg_reg  <= 11'd360;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MINOR_RADIUS:    minor_reg <= cfg_wdata;
                CFG_MAJOR_RADIUS:    major_reg <= cfg_wdata;
                CFG_RING_SEGMENTS:   rseg_reg  <= cfg_wdata[SEG_W-1:0];
                CFG_COLUMN_SEGMENTS: cseg_reg  <= cfg_wdata[SEG_W-1:0];
                default: ;
            endcase
        end
    end

    assign rseg_eff = (rseg_reg == '0) ? SEG_W'(1) : rseg_reg;
    assign cseg_eff = (cseg_reg == '0) ? SEG_W'(1) : cseg_reg;

    logic   en;
    issue_t iss;

    assign en = !m_valid || m_ready;

    tqv_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .iss     (iss)
    );

    logic signed [CW-1:0] cos_a, sin_a, cos_b, sin_b;
    logic [TEX_W-1:0]     tex_u, tex_v;

    tqv_angle u_ring (
        .aclk  (aclk),
        .en    (en),
        .idx   (iss.ri),
        .seg   (rseg_eff),
        .cos_o (cos_a),
        .sin_o (sin_a),
        .tex_o (tex_u)
    );

    tqv_angle u_col (
        .aclk  (aclk),
        .en    (en),
        .idx   (iss.cj),
        .seg   (cseg_eff),
        .cos_o (cos_b),
        .sin_o (sin_b),
        .tex_o (tex_v)
    );

    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;

    tqv_pos u_pos (
        .aclk         (aclk),
        .en           (en),
        .minor_radius (minor_reg),
        .major_radius (major_reg),
        .cos_a        (cos_a),
        .sin_a        (sin_a),
        .cos_b        (cos_b),
        .sin_b        (sin_b),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z)
    );

    logic                vld_reg [PIPE_LAT];
    logic [CORNER_W-1:0] cor_reg [PIPE_LAT];
    logic [TEX_W-1:0]    tu_reg  [POS_LAT];
    logic [TEX_W-1:0]    tv_reg  [POS_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '{default: 1'b0};
        end else if (en) begin
            vld_reg[0] <= iss.valid;
            for (int k = 1; k < PIPE_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
        if (en) begin
            cor_reg[0] <= iss.corner;
            for (int k = 1; k < PIPE_LAT; k++) begin
                cor_reg[k] <= cor_reg[k-1];
            end
            tu_reg[0] <= tex_u;
            tv_reg[0] <= tex_v;
            for (int k = 1; k < POS_LAT; k++) begin
                tu_reg[k] <= tu_reg[k-1];
                tv_reg[k] <= tv_reg[k-1];
            end
        end
    end

    assign m_valid = vld_reg[PIPE_LAT-1];

    always_comb begin
        m_data.pos_x         = pos_x;
        m_data.pos_y         = pos_y;
        m_data.pos_z         = pos_z;
        m_data.tex_u         = tu_reg[POS_LAT-1];
        m_data.tex_v         = tv_reg[POS_LAT-1];
        m_data.corner_number = cor_reg[PIPE_LAT-1];
        m_data.last_corner   = (cor_reg[PIPE_LAT-1] == LAST_CORNER);
    end

endmodule

### hw/rtl/tqv_checker.sv
// Port-level checks for the torus quad vertex generator, bound to the top level.
// Depends on tqv_pkg and torus_quad_vertex_generator.
module tqv_checker import tqv_pkg::*; (
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input quad_t   s_data,
    input logic    m_valid,
    input logic    m_ready,
    input vertex_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_quad_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken right after a request");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_corner == (m_data.corner_number == LAST_CORNER))
                    && (m_data.corner_number <= LAST_CORNER))
        else $error("corner number and last flag disagree");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind torus_quad_vertex_generator tqv_checker u_tqv_checker (.*);
